// ===== hdl/field_centric_mecanum_mixer_core_defines.svh =====
// Assertion macros for the field-centric mecanum mixer.
`ifndef FIELD_CENTRIC_MECANUM_MIXER_CORE_DEFINES_SVH
`define FIELD_CENTRIC_MECANUM_MIXER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define FCMM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("fcmm assertion failed");
// next-cycle implication
`define FCMM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("fcmm assertion failed");
`else
`define FCMM_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define FCMM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/fcmm_pkg.sv =====
// Shared widths, constants and the arctangent table of the mecanum mixer.
package fcmm_pkg;
	localparam int CORDIC_STEPS = 16;
	localparam int VW = 27;            // Q16 datapath width
	localparam int AW = 34;            // CORDIC angle accumulator width
	localparam int MB = 30;            // serial multiplier operand width
	localparam int PW = VW + MB;       // product width
	localparam int DW = 50;            // divider numerator width
	localparam int QW = 26;            // divider quotient width
	localparam logic [MB-1:0] GAIN_Q30 = 30'd652032874;
	localparam logic [VW-1:0] LEARN_DEN = 27'd8323072;   // 127 * 65536
	localparam logic [4:0] LEARN_K = 5'd25;
	localparam logic [4:0] NORM_K = 5'd7;

	// register map indexes
	localparam logic [2:0] REG_SLEW = 3'd0;
	localparam logic [2:0] REG_STICK_DZ = 3'd1;
	localparam logic [2:0] REG_POST_DZ = 3'd2;
	localparam logic [2:0] REG_ROT_DB = 3'd3;
	localparam logic [2:0] REG_MIN_DRIVE = 3'd4;
	localparam logic [2:0] REG_LEARN_GAIN = 3'd5;

	// arctangent of 2^-i in 2^-32 turns
	function automatic logic [31:0] atan_at(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0: r = 32'h20000000;
			5'd1: r = 32'h12E4051E;
			5'd2: r = 32'h09FB385B;
			5'd3: r = 32'h051111D4;
			5'd4: r = 32'h028B0D43;
			5'd5: r = 32'h0145D7E1;
			5'd6: r = 32'h00A2F61E;
			5'd7: r = 32'h00517C55;
			5'd8: r = 32'h0028BE53;
			5'd9: r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			default: r = 32'h0;
		endcase
		return r;
	endfunction
endpackage

// ===== hdl/fcmm_cmd_if.sv =====
// Stick command channel: one beat per control item.
interface fcmm_cmd_if;
	logic valid;
	logic ready;
	logic signed [7:0] forward_stick;
	logic signed [7:0] strafe_stick;
	logic signed [7:0] rotate_stick;
	logic [15:0] heading;
	logic field_centric;
	logic rezero;
	modport source(output valid, forward_stick, strafe_stick, rotate_stick, heading,
		field_centric, rezero, input ready);
	modport sink(input valid, forward_stick, strafe_stick, rotate_stick, heading,
		field_centric, rezero, output ready);
endinterface

// ===== hdl/fcmm_pwr_if.sv =====
// Wheel power channel: one beat per control item.
interface fcmm_pwr_if;
	logic valid;
	logic ready;
	logic signed [7:0] front_left_power;
	logic signed [7:0] front_right_power;
	logic signed [7:0] back_left_power;
	logic signed [7:0] back_right_power;
	modport source(output valid, front_left_power, front_right_power, back_left_power,
		back_right_power, input ready);
	modport sink(input valid, front_left_power, front_right_power, back_left_power,
		back_right_power, output ready);
endinterface

// ===== hdl/fcmm_mul.sv =====
// Bit-serial shift-add multiplier: signed by unsigned, one multiplier bit a cycle.
module fcmm_mul import fcmm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [VW-1:0] a,
	input  logic [MB-1:0]        b,
	output logic                 done,
	output logic signed [PW-1:0] prod
);
	logic busy_q, done_q;
	logic [4:0] cnt_q;
	logic signed [PW-1:0] acc_q, ash_q;
	logic [MB-1:0] b_q;

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(MB - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// accumulate shifted multiplicand where the multiplier bit is set
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			ash_q <= PW'(a);
			b_q <= b;
		end else if (busy_q) begin
			if (b_q[0]) acc_q <= acc_q + ash_q;
			ash_q <= ash_q <<< 1;
			b_q <= b_q >> 1;
		end
	end

	assign done = done_q;
	assign prod = acc_q;
endmodule

// ===== hdl/fcmm_div.sv =====
// Restoring divider: one quotient bit a cycle, quotient bits k down to 0.
module fcmm_div import fcmm_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] num,
	input  logic [VW-1:0] den,
	input  logic [4:0]    k,
	output logic          done,
	output logic [QW-1:0] quo
);
	logic busy_q, done_q;
	logic [4:0] cnt_q;
	logic [DW-1:0] rem_q, dsh_q;
	logic [QW-1:0] q_q;
	logic ge;

	assign ge = rem_q >= dsh_q;

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= k;
			end else if (busy_q) begin
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 5'd1;
				end
			end
		end
	end

	// trial subtract of the shifted divisor
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dsh_q <= DW'(den) << k;
			q_q <= '0;
		end else if (busy_q) begin
			if (ge) rem_q <= rem_q - dsh_q;
			q_q <= {q_q[QW-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign done = done_q;
	assign quo = q_q;
endmodule

// ===== hdl/fcmm_cordic.sv =====
// Iterative rotation-mode CORDIC on binary angles, one micro-rotation a cycle.
module fcmm_cordic import fcmm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [VW-1:0] x0,
	input  logic signed [VW-1:0] y0,
	input  logic [31:0]          theta,
	output logic                 done,
	output logic signed [VW-1:0] x,
	output logic signed [VW-1:0] y
);
	localparam logic signed [AW-1:0] QTR = 34'sh0_4000_0000;
	localparam logic signed [AW-1:0] HALF = 34'sh0_8000_0000;

	logic busy_q, done_q;
	logic [4:0] i_q;
	logic signed [VW-1:0] x_q, y_q, dx, dy;
	logic signed [AW-1:0] z_q, zs, at;

	assign zs = AW'(signed'(theta));
	assign dx = y_q >>> i_q;
	assign dy = x_q >>> i_q;
	assign at = AW'(atan_at(i_q));

	// iteration count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 5'd1;
				if (i_q == 5'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// half-turn pre-rotation, then micro-rotations
	always_ff @(posedge clk) begin
		if (start) begin
			if (zs > QTR) begin
				x_q <= -x0;
				y_q <= -y0;
				z_q <= zs - HALF;
			end else if (zs < -QTR) begin
				x_q <= -x0;
				y_q <= -y0;
				z_q <= zs + HALF;
			end else begin
				x_q <= x0;
				y_q <= y0;
				z_q <= zs;
			end
		end else if (busy_q) begin
			if (!z_q[AW-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
	end

	assign done = done_q;
	assign x = x_q;
	assign y = y_q;
endmodule

// ===== hdl/field_centric_mecanum_mixer_core.sv =====
// Field-centric mecanum mixer top level: control sequencer, registers, wheel slew.
// Robot-centric items go through mixing, then per wheel a normalise step, an optional scaling
// divide and a slew step. Field-centric adds the CORDIC rotation, two gain multiplies and
// a post-deadband step; a learning item adds one more multiply and a divide.
// One item in flight: the input is ready again in the cycle after the result loads;
// the result register frees the input side. arst_n clears state.
`include "field_centric_mecanum_mixer_core_defines.svh"
module field_centric_mecanum_mixer_core import fcmm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	fcmm_cmd_if.sink    cmd,
	fcmm_pwr_if.source  pwr,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_CORD = 4'd1;
	localparam logic [3:0] ST_GX = 4'd2;
	localparam logic [3:0] ST_GY = 4'd3;
	localparam logic [3:0] ST_POST = 4'd4;
	localparam logic [3:0] ST_LMUL = 4'd5;
	localparam logic [3:0] ST_LDIV = 4'd6;
	localparam logic [3:0] ST_MIX = 4'd7;
	localparam logic [3:0] ST_NORM = 4'd8;
	localparam logic [3:0] ST_NDIV = 4'd9;
	localparam logic [3:0] ST_SLEW = 4'd10;
	localparam logic [3:0] ST_OUT = 4'd11;
	localparam logic [VW-1:0] FULL_Q16 = 27'd8323072;   // 127 in Q16

	function automatic logic [7:0] abs8(input logic signed [7:0] v);
		return v[7] ? 8'(-v) : 8'(v);
	endfunction

	function automatic logic signed [7:0] dead8(input logic signed [7:0] v,
		input logic [6:0] dz);
		return (abs8(v) < {1'b0, dz}) ? 8'sd0 : v;
	endfunction

	function automatic logic signed [VW-1:0] q16(input logic signed [7:0] v);
		return {{(VW-24){v[7]}}, v, 16'h0};
	endfunction

	function automatic logic [VW-1:0] absv(input logic signed [VW-1:0] v);
		return v[VW-1] ? VW'(-v) : VW'(v);
	endfunction

	// product over 2^30, truncated toward zero
	function automatic logic signed [VW-1:0] trunc30(input logic signed [PW-1:0] p);
		logic signed [PW-1:0] adj;
		adj = p[PW-1] ? p + PW'(32'h3FFF_FFFF) : p;
		return VW'(adj >>> 30);
	endfunction

	// configuration registers
	logic [7:0] slew_q, min_drive_q;
	logic [6:0] stick_dz_q, post_dz_q, rot_db_q;
	logic [15:0] learn_gain_q;
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slew_q <= 8'd50;
			stick_dz_q <= 7'd5;
			post_dz_q <= 7'd8;
			rot_db_q <= 7'd6;
			min_drive_q <= 8'd25;
			learn_gain_q <= 16'd4270;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_SLEW: slew_q <= pwdata[7:0];
				REG_STICK_DZ: stick_dz_q <= pwdata[6:0];
				REG_POST_DZ: post_dz_q <= pwdata[6:0];
				REG_ROT_DB: rot_db_q <= pwdata[6:0];
				REG_MIN_DRIVE: min_drive_q <= pwdata[7:0];
				REG_LEARN_GAIN: learn_gain_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// register read-back
	always_comb begin
		case (paddr[4:2])
			REG_SLEW: prdata = {24'h0, slew_q};
			REG_STICK_DZ: prdata = {25'h0, stick_dz_q};
			REG_POST_DZ: prdata = {25'h0, post_dz_q};
			REG_ROT_DB: prdata = {25'h0, rot_db_q};
			REG_MIN_DRIVE: prdata = {24'h0, min_drive_q};
			REG_LEARN_GAIN: prdata = {16'h0, learn_gain_q};
			default: prdata = 32'h0;
		endcase
	end

	// control and datapath state
	logic [3:0] state_q;
	logic [31:0] zero_q;
	logic last_mode_q;
	logic signed [7:0] wp_q [4];
	logic out_valid_q;
	logic signed [7:0] out_q [4];
	logic signed [VW-1:0] fq_q, sq_q, rq_q;
	logic signed [7:0] r_q;
	logic signed [VW-1:0] mix_q [4];
	logic [VW-1:0] maxv_q;
	logic [1:0] k_q;
	logic neg_q;
	logic signed [7:0] t_q;

	// unit hookup
	logic cor_done, mul_start, mul_done, div_start, div_done;
	logic signed [VW-1:0] cor_x, cor_y, mul_a;
	logic [MB-1:0] mul_b;
	logic signed [PW-1:0] mul_p;
	logic [DW-1:0] div_num;
	logic [VW-1:0] div_den;
	logic [4:0] div_k;
	logic [QW-1:0] div_q;

	// item intake
	logic accept;
	logic signed [7:0] f_dz, s_dz, r_dz;
	logic [31:0] hq, zero_nx, theta;

	assign cmd.ready = (state_q == ST_IDLE);
	assign accept = cmd.valid && cmd.ready;
	assign f_dz = dead8(cmd.forward_stick, stick_dz_q);
	assign s_dz = dead8(cmd.strafe_stick, stick_dz_q);
	assign r_dz = dead8(cmd.rotate_stick, stick_dz_q);
	assign hq = {cmd.heading, 16'h0};

	always_comb begin
		zero_nx = zero_q;
		if (cmd.field_centric && !last_mode_q) zero_nx = hq;
		if (cmd.rezero) zero_nx = hq;
	end
	assign theta = zero_nx - hq;

	// post deadband and learning test
	logic signed [VW-1:0] fpd, spd;
	logic [VW-1:0] pd, afp, asp;
	logic learn;
	assign pd = VW'({post_dz_q, 16'h0});
	assign fpd = (absv(fq_q) < pd) ? '0 : fq_q;
	assign spd = (absv(sq_q) < pd) ? '0 : sq_q;
	assign afp = absv(fpd);
	assign asp = absv(spd);
	assign learn = (abs8(r_q) <= {1'b0, rot_db_q}) &&
		((VW+1)'(afp) + (VW+1)'(asp) > (VW+1)'({min_drive_q, 16'h0})) &&
		((VW+1)'(afp) > ((VW+1)'(asp) << 1));

	// mixing and largest magnitude
	logic signed [VW-1:0] mx [4];
	logic [VW-1:0] am [4], max01, max23;
	assign mx[0] = fq_q + sq_q + rq_q;
	assign mx[1] = fq_q - sq_q - rq_q;
	assign mx[2] = fq_q - sq_q + rq_q;
	assign mx[3] = fq_q + sq_q - rq_q;
	always_comb begin
		for (int j = 0; j < 4; j++) am[j] = absv(mx[j]);
	end
	assign max01 = (am[0] > am[1]) ? am[0] : am[1];
	assign max23 = (am[2] > am[3]) ? am[2] : am[3];

	// per-wheel target and slew
	logic signed [VW-1:0] mk;
	logic [VW-1:0] amk;
	logic [7:0] tmag;
	logic signed [9:0] diff, adiff, wstep;
	logic signed [7:0] wp_nx;
	assign mk = mix_q[k_q];
	assign amk = absv(mk);
	assign tmag = amk[23:16];
	assign diff = 10'(t_q) - 10'(wp_q[k_q]);
	assign adiff = diff[9] ? -diff : diff;
	always_comb begin
		if (adiff <= 10'(slew_q)) wstep = diff;
		else if (diff[9]) wstep = -10'(slew_q);
		else wstep = 10'(slew_q);
	end
	assign wp_nx = 8'(10'(wp_q[k_q]) + wstep);

	// learning nudge
	logic signed [QW:0] dq;
	assign dq = neg_q ? -(QW+1)'(div_q) : (QW+1)'(div_q);

	// unit starts and operands
	always_comb begin
		mul_start = 1'b0;
		mul_a = cor_x;
		mul_b = GAIN_Q30;
		div_start = 1'b0;
		div_num = (DW'(amk) << 7) - DW'(amk);
		div_den = maxv_q;
		div_k = NORM_K;
		case (state_q)
			ST_CORD: mul_start = cor_done;
			ST_GX: begin
				mul_start = mul_done;
				mul_a = cor_y;
			end
			ST_POST: begin
				mul_start = learn;
				mul_a = -spd;
				mul_b = MB'(learn_gain_q);
			end
			ST_LMUL: begin
				div_start = mul_done;
				div_num = (mul_p[PW-1] ? DW'(-mul_p) : DW'(mul_p)) << 7;
				div_den = LEARN_DEN;
				div_k = LEARN_K;
			end
			ST_NORM: div_start = (maxv_q > FULL_Q16);
			default: ;
		endcase
	end

	// sequencer and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			zero_q <= '0;
			last_mode_q <= 1'b0;
			out_valid_q <= 1'b0;
			k_q <= '0;
			for (int j = 0; j < 4; j++) wp_q[j] <= '0;
		end else begin
			// result register: loads when free or draining, clears when drained
			if (state_q == ST_OUT && (!out_valid_q || pwr.ready)) out_valid_q <= 1'b1;
			else if (pwr.valid && pwr.ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (accept) begin
					zero_q <= zero_nx;
					last_mode_q <= cmd.field_centric;
					state_q <= cmd.field_centric ? ST_CORD : ST_MIX;
				end
				ST_CORD: if (cor_done) state_q <= ST_GX;
				ST_GX: if (mul_done) state_q <= ST_GY;
				ST_GY: if (mul_done) state_q <= ST_POST;
				ST_POST: state_q <= learn ? ST_LMUL : ST_MIX;
				ST_LMUL: if (mul_done) state_q <= ST_LDIV;
				ST_LDIV: if (div_done) begin
					zero_q <= zero_q + 32'(dq);
					state_q <= ST_MIX;
				end
				ST_MIX: begin
					k_q <= '0;
					state_q <= ST_NORM;
				end
				ST_NORM: state_q <= (maxv_q > FULL_Q16) ? ST_NDIV : ST_SLEW;
				ST_NDIV: if (div_done) state_q <= ST_SLEW;
				ST_SLEW: begin
					wp_q[k_q] <= wp_nx;
					k_q <= k_q + 2'd1;
					state_q <= (k_q == 2'd3) ? ST_OUT : ST_NORM;
				end
				ST_OUT: if (!out_valid_q || pwr.ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (accept) begin
				fq_q <= q16(f_dz);
				sq_q <= q16(s_dz);
				rq_q <= q16(r_dz);
				r_q <= r_dz;
			end
			ST_GX: if (mul_done) fq_q <= trunc30(mul_p);
			ST_GY: if (mul_done) sq_q <= trunc30(mul_p);
			ST_POST: begin
				fq_q <= fpd;
				sq_q <= spd;
			end
			ST_LMUL: if (mul_done) neg_q <= mul_p[PW-1];
			ST_MIX: begin
				for (int j = 0; j < 4; j++) mix_q[j] <= mx[j];
				maxv_q <= (max01 > max23) ? max01 : max23;
			end
			ST_NORM: begin
				neg_q <= mk[VW-1];
				t_q <= mk[VW-1] ? -signed'(tmag) : signed'(tmag);
			end
			ST_NDIV: if (div_done) t_q <= neg_q ? -signed'(div_q[7:0]) : signed'(div_q[7:0]);
			ST_OUT: if (!out_valid_q || pwr.ready) begin
				for (int j = 0; j < 4; j++) out_q[j] <= wp_q[j];
			end
			default: ;
		endcase
	end

	assign pwr.valid = out_valid_q;
	assign pwr.front_left_power = out_q[0];
	assign pwr.front_right_power = out_q[1];
	assign pwr.back_left_power = out_q[2];
	assign pwr.back_right_power = out_q[3];

	fcmm_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .start(accept && cmd.field_centric),
		.x0(q16(f_dz)), .y0(q16(s_dz)), .theta(theta),
		.done(cor_done), .x(cor_x), .y(cor_y)
	);

	fcmm_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.done(mul_done), .prod(mul_p)
	);

	fcmm_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.k(div_k), .done(div_done), .quo(div_q)
	);

	`FCMM_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, accept, state_q != ST_IDLE)
	`FCMM_ASSERT_NOW(a_fl_range, clk, arst_n, pwr.valid, pwr.front_left_power != -8'sd128)
	`FCMM_ASSERT_NOW(a_br_range, clk, arst_n, pwr.valid, pwr.back_right_power != -8'sd128)
	`FCMM_ASSERT_NOW(a_div_phase, clk, arst_n, div_done, state_q == ST_LDIV || state_q == ST_NDIV)
endmodule

// ===== dv/tb_field_centric_mecanum_mixer_core.sv =====
// Self-checking testbench for the field-centric mecanum mixer core.
`timescale 1ns / 100ps

module tb_field_centric_mecanum_mixer_core;
	import fcmm_pkg::*;

	localparam logic [2:0] REG_UNUSED = 3'd6;
	localparam int N_PHASES = 6;
	localparam int RAND_PER_PHASE = 100;
	localparam int DRAIN_CYCLES = 200;

	typedef struct {
		logic signed [7:0] fwd;
		logic signed [7:0] str;
		logic signed [7:0] rot;
		logic [15:0] heading;
		logic fc;
		logic rz;
	} stick_cmd_t;

	typedef struct {
		logic signed [7:0] wheel [4];
	} wheel_pwr_t;

	// Scoreboard: mixer prediction and expected wheel powers
	class mixer_scoreboard;
		int slew, stick_dz, post_dz, rot_db, min_drv, gain;
		logic [31:0] zero_ang;
		bit prev_fc;
		int wheel [4];
		wheel_pwr_t pending [$];
		int errors;
		logic [31:0] atan_lut [24] = '{
			32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
			32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
			32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
			32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
			32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};

		function new();
			slew = 50; stick_dz = 5; post_dz = 8; rot_db = 6; min_drv = 25; gain = 4270;
			zero_ang = '0; prev_fc = 0;
			foreach (wheel[k]) wheel[k] = 0;
			errors = 0;
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		function void set_reg(logic [2:0] idx, logic [31:0] val);
			case (idx)
				REG_SLEW: slew = int'(val[7:0]);
				REG_STICK_DZ: stick_dz = int'(val[6:0]);
				REG_POST_DZ: post_dz = int'(val[6:0]);
				REG_ROT_DB: rot_db = int'(val[6:0]);
				REG_MIN_DRIVE: min_drv = int'(val[7:0]);
				REG_LEARN_GAIN: gain = int'(val[15:0]);
				default: ;
			endcase
		endfunction

		static function longint mag(longint v);
			return (v < 0) ? -v : v;
		endfunction

		// CORDIC rotation on Q16 values, binary angle, gain removed in Q30
		function void rotate_vec(inout longint x, inout longint y, input logic [31:0] th);
			longint z, dx, dy;
			z = longint'(int'(th));
			if (z > 64'sd1073741824) begin
				x = -x; y = -y; z -= 64'sd2147483648;
			end else if (z < -64'sd1073741824) begin
				x = -x; y = -y; z += 64'sd2147483648;
			end
			for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx; y += dy; z -= longint'(atan_lut[i]);
				end else begin
					x += dx; y -= dy; z += longint'(atan_lut[i]);
				end
			end
			x = (x * 64'sd652032874) / 64'sd1073741824;
			y = (y * 64'sd652032874) / 64'sd1073741824;
		endfunction

		// accepted command: work out the wheel powers it should produce
		function void note_cmd(stick_cmd_t c);
			longint f, s, r, fq, sq, rq, pd, d, maxv, t, diff;
			longint mix [4];
			logic [31:0] ang;
			wheel_pwr_t res;
			f = longint'(c.fwd); s = longint'(c.str); r = longint'(c.rot);
			if (mag(f) < stick_dz) f = 0;
			if (mag(s) < stick_dz) s = 0;
			if (mag(r) < stick_dz) r = 0;
			// mode-entry capture first, then re-zero
			if (c.fc && !prev_fc) zero_ang = {c.heading, 16'h0};
			prev_fc = c.fc;
			if (c.rz) zero_ang = {c.heading, 16'h0};
			fq = f * 65536; sq = s * 65536; rq = r * 65536;
			if (c.fc) begin
				ang = {c.heading, 16'h0} - zero_ang;
				pd = longint'(post_dz) * 65536;
				rotate_vec(fq, sq, 32'h0 - ang);
				if (mag(fq) < pd) fq = 0;
				if (mag(sq) < pd) sq = 0;
				// drift learning while driving mostly straight
				if (mag(r) <= rot_db && mag(fq) + mag(sq) > longint'(min_drv) * 65536
						&& mag(fq) > 2 * mag(sq)) begin
					d = (-sq * longint'(gain) * 128) / (64'sd127 * 65536);
					zero_ang += d[31:0];
				end
			end
			mix[0] = fq + sq + rq;
			mix[1] = fq - sq - rq;
			mix[2] = fq - sq + rq;
			mix[3] = fq + sq - rq;
			maxv = 0;
			foreach (mix[k]) if (mag(mix[k]) > maxv) maxv = mag(mix[k]);
			foreach (mix[k]) begin
				if (maxv > 64'sd127 * 65536) t = (mix[k] * 127) / maxv;
				else t = mix[k] / 65536;
				diff = t - wheel[k];
				if (mag(diff) <= slew) wheel[k] = int'(t);
				else wheel[k] += (diff > 0) ? slew : -slew;
				res.wheel[k] = wheel[k][7:0];
			end
			pending.push_back(res);
		endfunction

		task check_pwr(wheel_pwr_t got);
			wheel_pwr_t exp_pwr;
			if (pending.size() == 0) begin
				report("wheel power beat with nothing outstanding");
				return;
			end
			exp_pwr = pending.pop_front();
			foreach (got.wheel[k])
				if (got.wheel[k] !== exp_pwr.wheel[k])
					report($sformatf("wheel %0d got %0d want %0d", k, got.wheel[k],
						exp_pwr.wheel[k]));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [4:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;

	fcmm_cmd_if cmd_ch();
	fcmm_pwr_if pwr_ch();

	field_centric_mecanum_mixer_core dut (
		.clk(clk), .arst_n(arst_n), .cmd(cmd_ch.sink), .pwr(pwr_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	mixer_scoreboard sb = new();
	int burst_left = 0;
	int hold_left = 0;
	logic [15:0] walk_heading = '0;

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// monitors
	always @(posedge clk) begin
		stick_cmd_t c;
		wheel_pwr_t w;
		if (arst_n && cmd_ch.valid && cmd_ch.ready) begin
			c.fwd = cmd_ch.forward_stick; c.str = cmd_ch.strafe_stick;
			c.rot = cmd_ch.rotate_stick; c.heading = cmd_ch.heading;
			c.fc = cmd_ch.field_centric; c.rz = cmd_ch.rezero;
			sb.note_cmd(c);
		end
		if (arst_n && pwr_ch.valid && pwr_ch.ready) begin
			w.wheel[0] = pwr_ch.front_left_power; w.wheel[1] = pwr_ch.front_right_power;
			w.wheel[2] = pwr_ch.back_left_power; w.wheel[3] = pwr_ch.back_right_power;
			sb.check_pwr(w);
		end
	end

	// receiver: changing stall pattern, one long hold-off
	initial begin
		int cyc;
		int mode;
		cyc = 0; mode = 0;
		pwr_ch.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			cyc++;
			if (cyc % 64 == 0) mode = $urandom_range(0, 3);
			if (cyc == 3000) hold_left = 600;
			if (hold_left > 0) begin
				hold_left--;
				pwr_ch.ready <= 1'b0;
			end else begin
				case (mode)
					0: pwr_ch.ready <= 1'b1;
					1: pwr_ch.ready <= ($urandom_range(0, 1) == 1);
					2: pwr_ch.ready <= ($urandom_range(0, 4) != 0);
					default: pwr_ch.ready <= ($urandom_range(0, 5) == 0);
				endcase
			end
			@(posedge clk);
		end
	end

	// one beat on the command channel, bursts with random gaps
	task send_cmd(stick_cmd_t c);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 12);
			if (gap > 0) begin
				cmd_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 10);
		end
		burst_left--;
		cmd_ch.valid <= 1'b1;
		cmd_ch.forward_stick <= c.fwd;
		cmd_ch.strafe_stick <= c.str;
		cmd_ch.rotate_stick <= c.rot;
		cmd_ch.heading <= c.heading;
		cmd_ch.field_centric <= c.fc;
		cmd_ch.rezero <= c.rz;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
	endtask

	task drive_cmd(int f, int s, int r, int h, bit fc, bit rz);
		stick_cmd_t c;
		c.fwd = f[7:0]; c.str = s[7:0]; c.rot = r[7:0];
		c.heading = h[15:0]; c.fc = fc; c.rz = rz;
		send_cmd(c);
	endtask

	// wait for every expected beat, then let the core settle
	task drain();
		cmd_ch.valid <= 1'b0;
		burst_left = 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task write_reg(logic [2:0] idx, logic [31:0] val);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.set_reg(idx, val);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task set_config(int sr, int sdz, int pdz, int rdb, int md, int lg);
		write_reg(REG_SLEW, sr);
		write_reg(REG_STICK_DZ, sdz);
		write_reg(REG_POST_DZ, pdz);
		write_reg(REG_ROT_DB, rdb);
		write_reg(REG_MIN_DRIVE, md);
		write_reg(REG_LEARN_GAIN, lg);
	endtask

	// random command: mostly steady field-centric driving, some noise
	task send_random();
		stick_cmd_t c;
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 25) begin
			c.fwd = 8'($urandom); c.str = 8'($urandom); c.rot = 8'($urandom);
			c.heading = 16'($urandom); c.fc = 1'($urandom); c.rz = 1'($urandom);
		end else begin
			walk_heading += $urandom_range(0, 1) ? 16'($urandom_range(0, 600))
				: 16'(-$urandom_range(0, 600));
			if ($urandom_range(0, 19) == 0) walk_heading = 16'($urandom);
			c.heading = walk_heading;
			c.fwd = $urandom_range(0, 1) ? 8'($urandom_range(20, 127))
				: 8'(-$urandom_range(20, 128));
			c.str = $urandom_range(0, 2) == 0 ? 8'($urandom) : 8'($urandom_range(0, 12) - 6);
			c.rot = $urandom_range(0, 2) == 0 ? 8'($urandom) : 8'($urandom_range(0, 14) - 7);
			c.fc = ($urandom_range(0, 24) != 0);
			c.rz = ($urandom_range(0, 24) == 0);
		end
		send_cmd(c);
	endtask

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
		cmd_ch.valid <= 1'b0; cmd_ch.forward_stick <= '0; cmd_ch.strafe_stick <= '0;
		cmd_ch.rotate_stick <= '0; cmd_ch.heading <= '0;
		cmd_ch.field_centric <= 1'b0; cmd_ch.rezero <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, scaling, mode entry, re-zero, learning
		drive_cmd(127, 127, 127, 0, 0, 0);
		drive_cmd(-128, -128, -128, 16'hFFFF, 0, 0);
		drive_cmd(-128, 127, 0, 0, 0, 0);
		drive_cmd(4, -4, 3, 0, 0, 0);
		drive_cmd(0, 0, 0, 16'h1234, 0, 1);
		drive_cmd(100, 0, 0, 16'h4000, 1, 0);
		drive_cmd(100, 0, 0, 16'h8000, 1, 0);
		drive_cmd(100, 20, 0, 16'hC000, 1, 0);
		drive_cmd(127, -10, 0, 16'h4000, 1, 1);
		drive_cmd(127, 10, 0, 16'h4100, 1, 0);
		drive_cmd(127, -12, 2, 16'h3F00, 1, 0);
		drive_cmd(120, 9, 0, 16'h4000, 1, 0);
		drive_cmd(-127, 0, 127, 16'hFFFF, 1, 0);
		drive_cmd(-128, -128, 0, 16'h7FFF, 1, 0);
		drive_cmd(50, 50, 0, 16'h2000, 0, 0);
		drive_cmd(50, 50, 0, 16'hE000, 1, 1);
		drive_cmd(0, 0, 0, 0, 0, 0);
		drain();

		// zero slew: powers hold until the target equals them
		write_reg(REG_SLEW, 0);
		drive_cmd(127, 0, 0, 0, 0, 0);
		drive_cmd(0, 0, 0, 0, 0, 0);
		drain();
		write_reg(REG_UNUSED, 32'hFFFF_FFFF);

		for (int p = 0; p < N_PHASES; p++) begin
			drain();
			case (p)
				0: set_config(50, 5, 8, 6, 25, 4270);
				1: set_config(255, 0, 0, 127, 0, 65535);
				2: set_config(1, 127, 127, 0, 254, 0);
				3: set_config(0, 3, 4, 10, 10, 30000);
				4: set_config($urandom_range(1, 255), $urandom_range(0, 127),
					$urandom_range(0, 127), $urandom_range(0, 127),
					$urandom_range(0, 254), $urandom_range(0, 65535));
				default: set_config(20, 2, 2, 20, 5, 65535);
			endcase
			for (int i = 0; i < RAND_PER_PHASE; i++) send_random();
		end
		drain();

		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+hdl
hdl/fcmm_pkg.sv
hdl/fcmm_cmd_if.sv
hdl/fcmm_pwr_if.sv
hdl/fcmm_mul.sv
hdl/fcmm_div.sv
hdl/fcmm_cordic.sv
hdl/field_centric_mecanum_mixer_core.sv
dv/tb_field_centric_mecanum_mixer_core.sv
